// ===== sv/assert_macros.svh =====
// Assertion macros used by the top unit of the decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

// ===== sv/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character classifier of the URL-safe decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // input command codes
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // classifier codes: skip and invalid lie outside the 6-bit range, underscore is 37
    localparam logic [6:0] CODE_INVALID    = 7'h7f;
    localparam logic [6:0] CODE_SKIP       = 7'h7e;
    localparam logic [6:0] CODE_UNDERSCORE = 7'h25;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // result kinds
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_ERR  = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    // one result word
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic        last;
    } t_result;

    // all result words caused by one input word (cnt is 1..3)
    typedef struct packed {
        logic [1:0]        cnt;
        t_result [2:0]     res;
    } t_job;

    // map a character to its 6-bit code, or to the skip or invalid code
    function automatic logic [6:0] char_code(input logic [7:0] c);
        logic [6:0] code;
        code = CODE_INVALID;
        priority if (c == 8'h09 || c == 8'h0a || c == 8'h0d || c == 8'h20) begin
            code = CODE_SKIP;
        end else if (c == 8'h2d) begin
            code = 7'd0;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            code = 7'(c - 8'h2f);
        end else if (c >= 8'h41 && c <= 8'h5a) begin
            code = 7'(c - 8'h36);
        end else if (c == 8'h5f) begin
            code = CODE_UNDERSCORE;
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            code = 7'(c - 8'h3b);
        end else begin
            code = CODE_INVALID;
        end
        return code;
    endfunction

endpackage

// ===== sv/b64d_ifs.sv =====
// ----------------------------------------------------------------------------
// b64d_in_if / b64d_out_if
// Valid/ready channels for character words in and result words out.
// ----------------------------------------------------------------------------
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] char_in;

    modport source (output valid, output cmd, output char_in, input ready);
    modport sink   (input valid, input cmd, input char_in, output ready);
endinterface

interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_value;
    logic       last;

    modport source (output valid, output kind, output out_value, output last,
                    input ready);
    modport sink   (input valid, input kind, input out_value, input last,
                    output ready);
endinterface

// ===== sv/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Accepts character words, keeps the partial group and builds result jobs.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    b64d_in_if.sink         i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output b64d_pkg::t_job  o_job
);
    import b64d_pkg::*;

    logic [17:0] r_group_bits, n_group_bits;
    logic [1:0]  r_group_count, n_group_count;
    logic        w_accept;
    logic [6:0]  w_code;

    assign i_in.ready = !i_q_full;
    assign w_accept   = i_in.valid && !i_q_full;
    assign w_code     = char_code(i_in.char_in);

    // classify the word and form its job
    always_comb begin
        n_group_bits  = r_group_bits;
        n_group_count = r_group_count;
        o_push        = 1'b0;
        o_job         = '0;
        if (w_accept) begin
            if (i_in.cmd == CMD_END) begin
                o_push = 1'b1;
                unique case (r_group_count)
                    2'd2: begin
                        o_job.cnt    = 2'd2;
                        o_job.res[0] = '{KIND_BYTE, r_group_bits[11:4], 1'b0};
                        o_job.res[1] = '{KIND_END, 8'h00, 1'b1};
                    end
                    2'd3: begin
                        o_job.cnt    = 2'd3;
                        o_job.res[0] = '{KIND_BYTE, r_group_bits[17:10], 1'b0};
                        o_job.res[1] = '{KIND_BYTE, r_group_bits[9:2], 1'b0};
                        o_job.res[2] = '{KIND_END, 8'h00, 1'b1};
                    end
                    default: begin
                        o_job.cnt    = 2'd1;
                        o_job.res[0] = '{KIND_END, 8'h00, 1'b1};
                    end
                endcase
                n_group_bits  = '0;
                n_group_count = '0;
            end else if (w_code == CODE_SKIP) begin
                o_push = 1'b0;
            end else if (w_code == CODE_INVALID) begin
                o_push       = 1'b1;
                o_job.cnt    = 2'd1;
                o_job.res[0] = '{KIND_ERR, i_in.char_in, 1'b1};
            end else if (r_group_count == 2'd3) begin
                // fourth code completes the group: three bytes
                o_push       = 1'b1;
                o_job.cnt    = 2'd3;
                o_job.res[0] = '{KIND_BYTE, r_group_bits[17:10], 1'b0};
                o_job.res[1] = '{KIND_BYTE, r_group_bits[9:2], 1'b0};
                o_job.res[2] = '{KIND_BYTE, {r_group_bits[1:0], w_code[5:0]}, 1'b1};
                n_group_bits  = '0;
                n_group_count = '0;
            end else begin
                n_group_bits  = {r_group_bits[11:0], w_code[5:0]};
                n_group_count = r_group_count + 2'd1;
            end
        end
    end

    // group accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_bits  <= '0;
            r_group_count <= '0;
        end else begin
            r_group_bits  <= n_group_bits;
            r_group_count <= n_group_count;
        end
    end

endmodule

// ===== sv/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue
// Short job queue that decouples the classifier from the output side.
// ----------------------------------------------------------------------------
module b64d_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64d_pkg::t_job  i_job,
    input  logic            i_pop,
    output b64d_pkg::t_job  o_job,
    output logic            o_full,
    output logic            o_empty
);
    import b64d_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Walks the words of the head job into the registered output port.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  b64d_pkg::t_job  i_job,
    input  logic            i_q_empty,
    output logic            o_pop,
    b64d_out_if.source      o_out
);
    import b64d_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_result    r_res;
    logic       w_take;
    logic       w_final;

    assign w_take  = !i_q_empty && (!r_valid || o_out.ready);
    assign w_final = (r_idx == i_job.cnt - 2'd1);
    assign o_pop   = w_take && w_final;

    // word index within the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_valid <= 1'b1;
                r_idx   <= w_final ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_res <= i_job.res[r_idx];
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.kind      = r_res.kind;
    assign o_out.out_value = r_res.value;
    assign o_out.last      = r_res.last;

endmodule

// ===== sv/base64_variant_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// base64_variant_stream_decoder_unit
// URL-safe base64 variant decoder: characters in, bytes and status words out.
// ----------------------------------------------------------------------------
// The input port takes one word per cycle as long as the four-entry job queue
// has room; ready depends only on the queue level. Each accepted word yields
// zero to three result words, three for a full group of four characters; they
// leave the output register one per cycle while the output is ready. A word's
// job is written into the queue, its first result then into the output
// register. Sustained input rate is one word per cycle while the stream
// averages at most one result per word, else the single output port sets pace.
module base64_variant_stream_decoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64d_in_if.sink     i_in,
    b64d_out_if.source  o_out
);
    import b64d_pkg::*;
    `include "assert_macros.svh"

    t_job w_push_job, w_head_job;
    logic w_push, w_pop, w_full, w_empty;

    // classifier and group accumulator
    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_q_full(w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    // job queue
    b64d_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_push_job),
        .i_pop  (w_pop),
        .o_job  (w_head_job),
        .o_full (w_full),
        .o_empty(w_empty)
    );

    // result serializer
    b64d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_head_job),
        .i_q_empty(w_empty),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    // checks
    `ASSERT_NEVER(a_push_when_full, i_clk, i_rst_n, w_push && w_full)
    `ASSERT_NEVER(a_pop_when_empty, i_clk, i_rst_n, w_pop && w_empty)
    `ASSERT_CLK(a_pop_ends_job, i_clk, i_rst_n, w_pop |=> (o_out.valid && o_out.last))

endmodule
